// ===== rtl/free_list_block_allocator_defines.svh =====
// Assertion macros shared by the allocator's checker.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("free list allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("free list allocator check failed");

`endif

// ===== rtl/fla_pkg.sv =====
// Shared types, codes and constants of the free list block allocator.
package fla_pkg;

  localparam int IDX_W          = 10;
  localparam int CNT_W          = 11;
  localparam int MODE_W         = 2;
  localparam int MAX_BLOCKS_DEF = 1024;

  // Item modes; the fourth code is unused and only returns an OK result with no grant.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    status_t          status;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    rd_head;
    logic    pop;
    logic    push;
    logic    set_empty;
    logic    sweep_start;
    logic    sweep_step;
    logic    res_valid;
    status_t res_status;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic list_empty;
    logic cnt_zero;
    logic idx_in_range;
    logic sweep_last;
  } dp_stat_t;

endpackage

// ===== rtl/fla_ctrl.sv =====
// Controller state machine of the free list block allocator.
module fla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [fla_pkg::MODE_W-1:0] mode,
  input  fla_pkg::dp_stat_t stat,
  output fla_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  fla_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fla_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = fla_pkg::ST_OK;
    busy           = 1'b1;
    case (state_r)
      fla_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (mode)
            fla_pkg::MODE_ALLOC: begin
              if (stat.list_empty) begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = fla_pkg::ST_EMPTY;
              end else begin
                // fetch the head's link, pop once it lands
                cmd.rd_head = 1'b1;
                state_nxt   = fla_pkg::S_ALLOC;
              end
            end
            fla_pkg::MODE_FREE: begin
              cmd.res_valid = 1'b1;
              if (stat.idx_in_range) begin
                cmd.push = 1'b1;
              end else begin
                cmd.res_status = fla_pkg::ST_RANGE;
              end
            end
            fla_pkg::MODE_CLEAR: begin
              if (stat.cnt_zero) begin
                cmd.set_empty = 1'b1;
                cmd.res_valid = 1'b1;
              end else begin
                cmd.sweep_start = 1'b1;
                state_nxt       = fla_pkg::S_CLEAR;
              end
            end
            default: begin
              cmd.res_valid = 1'b1;
            end
          endcase
        end
      end
      fla_pkg::S_ALLOC: begin
        cmd.pop       = 1'b1;
        cmd.res_valid = 1'b1;
        state_nxt     = fla_pkg::S_IDLE;
      end
      fla_pkg::S_CLEAR: begin
        // write one link a cycle until the last block
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.res_valid = 1'b1;
          state_nxt     = fla_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fla_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fla_dp.sv =====
// Datapath of the free list block allocator: link memory, head, count, result.
module fla_dp #(
  parameter int MAX_BLOCKS = fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fla_pkg::in_item_t          in_item,
  input  logic                       cfg_we,
  input  logic [fla_pkg::CNT_W-1:0]  cfg_wdata,
  input  fla_pkg::dp_cmd_t           cmd,
  output fla_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  output fla_pkg::out_item_t         out_item
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = (fla_pkg::CNT_W > AW + 1) ? fla_pkg::CNT_W : AW + 1;
  localparam int DW = AW + 1;

  // Link memory: {end marker, next link}
  logic [DW-1:0] link_mem [MAX_BLOCKS];
  logic [DW-1:0] rd_q;

  logic [AW-1:0]               head_r, head_nxt;
  logic                        empty_r, empty_nxt;
  logic [fla_pkg::CNT_W-1:0]   cnt_r;
  logic [AW-1:0]               swp_r, swp_nxt;
  logic                        out_valid_r;
  fla_pkg::out_item_t          out_item_r, out_item_nxt;

  logic [CW-1:0] eff_cnt;
  logic [CW-1:0] cnt_ext;
  logic          swp_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  // Clamp the count to the memory depth
  assign cnt_ext  = CW'(cnt_r);
  assign eff_cnt  = (cnt_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : cnt_ext;
  assign swp_last = (CW'(swp_r) + CW'(1)) == eff_cnt;

  assign stat.list_empty   = empty_r;
  assign stat.cnt_zero     = (eff_cnt == '0);
  assign stat.idx_in_range = CW'(in_item.block_index) < eff_cnt;
  assign stat.sweep_last   = swp_last;

  // Select the write for a push or a sweep step
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = swp_r;
    mem_wdata = '0;
    if (cmd.push) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(in_item.block_index);
      mem_wdata = {empty_r, head_r};
    end else if (cmd.sweep_step) begin
      mem_we    = 1'b1;
      mem_waddr = swp_r;
      mem_wdata = swp_last ? {1'b1, {AW{1'b0}}} : {1'b0, AW'(swp_r + 1'b1)};
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_head) begin
      rd_q <= link_mem[head_r];
    end
  end

  // Head, empty flag, sweep counter and result
  always_comb begin
    head_nxt  = head_r;
    empty_nxt = empty_r;
    swp_nxt   = swp_r;
    out_item_nxt.granted_index = '0;
    out_item_nxt.status        = cmd.res_status;
    if (cmd.pop) begin
      out_item_nxt.granted_index = fla_pkg::IDX_W'(head_r);
      empty_nxt = rd_q[DW-1];
      head_nxt  = rd_q[DW-1] ? '0 : rd_q[AW-1:0];
    end
    if (cmd.push) begin
      head_nxt  = AW'(in_item.block_index);
      empty_nxt = 1'b0;
    end
    if (cmd.set_empty) begin
      head_nxt  = '0;
      empty_nxt = 1'b1;
    end
    if (cmd.sweep_start) begin
      swp_nxt = '0;
    end
    if (cmd.sweep_step) begin
      swp_nxt = AW'(swp_r + 1'b1);
      if (swp_last) begin
        head_nxt  = '0;
        empty_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      empty_r     <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= cmd.res_valid;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    swp_r <= swp_nxt;
    if (cmd.res_valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/free_list_block_allocator.sv =====
// Top level of the free list block allocator.
// An item is taken at a clock edge with start high and busy low; its one result
// appears on out_item for exactly one cycle with out_valid high, and the receiver
// cannot stall it, so it must be captured in that cycle. A free, an allocate on
// an empty list, an unused mode and a clear of zero blocks answer straight from
// the idle state. An allocate that grants waits in S_ALLOC for the registered
// read of the head's link. A clear relinks blocks through the single link-memory
// write port, one block per cycle, for block_count blocks (capped at MAX_BLOCKS).
// busy stays high while an item is in progress. A new item may be started in the
// cycle its predecessor's result is shown. Write block_count only while the block
// is idle; the list is empty after reset until a free or a clear item fills it.
module free_list_block_allocator #(
  parameter int MAX_BLOCKS = fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  fla_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output fla_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [fla_pkg::CNT_W-1:0] cfg_wdata
);

  fla_pkg::dp_cmd_t  cmd;
  fla_pkg::dp_stat_t stat;

  fla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fla_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/fla_checker.sv =====
// Port-level checks of the free list block allocator, bound to the top level.
`include "free_list_block_allocator_defines.svh"

module fla_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input fla_pkg::in_item_t  in_item,
  input logic               out_valid,
  input fla_pkg::out_item_t out_item
);

  logic acc;
  assign acc = start && !busy;

  // A free item answers in the next cycle and leaves the block idle
  `FLA_ASSERT_NEXT(a_free_one_cycle, clk, rst_n, acc && (in_item.mode == fla_pkg::MODE_FREE), out_valid && !busy)

  // A clear item either answers at once or keeps the block busy
  `FLA_ASSERT_NEXT(a_clear_progress, clk, rst_n, acc && (in_item.mode == fla_pkg::MODE_CLEAR), busy || out_valid)

  // A failed item grants nothing
  `FLA_ASSERT_NOW(a_fail_no_grant, clk, rst_n, out_valid && (out_item.status != fla_pkg::ST_OK), out_item.granted_index == '0)

  // An empty-pool result only follows an accepted allocate
  `FLA_ASSERT_NOW(a_empty_from_alloc, clk, rst_n, out_valid && (out_item.status == fla_pkg::ST_EMPTY), $past(acc && (in_item.mode == fla_pkg::MODE_ALLOC)))

endmodule

bind free_list_block_allocator fla_checker u_fla_checker (.*);

// ===== bench/free_list_block_allocator_tb.sv =====
// Self-checking testbench for the free list block allocator.
`timescale 1ns / 1ps

module free_list_block_allocator_tb;
  import fla_pkg::*;

  localparam int MAXB = MAX_BLOCKS_DEF;
  localparam int SETTLE = 4;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  free_list_block_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Items waiting to be sent, and results owed by the allocator
  in_item_t pending_items[$];
  out_item_t expected_grants[$];

  // Shadow of the free list and the block count
  logic [IDX_W-1:0] next_tab [MAXB];
  logic last_tab [MAXB];
  logic [IDX_W-1:0] free_head = '0;
  logic pool_empty = 1'b1;
  logic [CNT_W-1:0] count_shadow = '0;

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int quiet_run = 0;
  bit in_flight = 1'b0;
  bit hold_for_drain = 1'b0;

  // Work out the result of one item and advance the shadow list
  function automatic out_item_t alloc_predict(in_item_t it);
    out_item_t res;
    int unsigned cnt;
    res.granted_index = '0;
    res.status = ST_OK;
    cnt = (count_shadow > MAXB) ? MAXB : count_shadow;
    case (it.mode)
      MODE_ALLOC: begin
        if (pool_empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.granted_index = free_head;
          if (last_tab[free_head]) begin
            pool_empty = 1'b1;
            free_head = '0;
          end else begin
            free_head = next_tab[free_head];
          end
        end
      end
      MODE_FREE: begin
        if (it.block_index >= cnt) begin
          res.status = ST_RANGE;
        end else begin
          next_tab[it.block_index] = free_head;
          last_tab[it.block_index] = pool_empty;
          free_head = it.block_index;
          pool_empty = 1'b0;
        end
      end
      MODE_CLEAR: begin
        free_head = '0;
        if (cnt == 0) begin
          pool_empty = 1'b1;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            next_tab[i] = (i + 1 < cnt) ? IDX_W'(i + 1) : '0;
            last_tab[i] = (i + 1 == cnt);
          end
          pool_empty = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly back-to-back or short gaps, a few long ones, and runs with none
  function automatic int pick_gap();
    int r;
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_run = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send items: hold each until accepted, predict it on acceptance
  always @(posedge clk) begin : drive_proc
    in_item_t nxt;
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (cfg_we) count_shadow = cfg_wdata;
      go = start;
      nxt = in_item;
      if (start && !busy) begin
        expected_grants.push_back(alloc_predict(in_item));
        in_flight = 1'b0;
        go = 1'b0;
        gap_left = pick_gap();
      end
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(hold_for_drain && expected_grants.size() != 0)) begin
          nxt = pending_items.pop_front();
          go = 1'b1;
          in_flight = 1'b1;
          hold_for_drain = ($urandom_range(0, 39) == 0);
        end
      end
      start <= go;
      in_item <= nxt;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result: granted_index %0d status %0d",
               out_item.granted_index, out_item.status);
        fail_cnt++;
      end else begin
        want = expected_grants.pop_front();
        if (out_item.granted_index !== want.granted_index) begin
          $error("granted_index: expected %0d, got %0d",
                 want.granted_index, out_item.granted_index);
          fail_cnt++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("free_list_block_allocator_tb: FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx);
    in_item_t it;
    it.mode = m;
    it.block_index = idx;
    return it;
  endfunction

  // Random item, weighted towards allocate and in-range free
  function automatic in_item_t rand_item(int unsigned eff);
    int r;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    idx = $urandom_range(0, MAXB - 1);
    if (r < 48) return mk(MODE_ALLOC, idx);
    if (r < 88) return mk(MODE_FREE, (eff > 0) ? IDX_W'($urandom_range(0, eff - 1)) : idx);
    if (r < 93) return mk(MODE_FREE, (eff < MAXB) ? IDX_W'($urandom_range(eff, MAXB - 1)) : idx);
    if (r < 96) return mk(MODE_CLEAR, idx);
    return mk(MODE_NONE, idx);
  endfunction

  // Wait until every item is sent and answered, then let the block settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_flight || expected_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim_proc
    int unsigned counts [10] = '{1024, 2047, 1, 0, 7, 1023, 2, 64, 300, 3};
    int unsigned eff;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list after reset, zero count, unused mode
    pending_items.push_back(mk(MODE_ALLOC, '0));
    pending_items.push_back(mk(MODE_FREE, '0));
    pending_items.push_back(mk(MODE_CLEAR, '0));
    pending_items.push_back(mk(MODE_NONE, '1));
    wait_idle();

    // Small pool: drain it, push back, range errors at both ends
    write_count(4);
    pending_items.push_back(mk(MODE_CLEAR, '0));
    repeat (5) pending_items.push_back(mk(MODE_ALLOC, '1));
    pending_items.push_back(mk(MODE_FREE, 3));
    pending_items.push_back(mk(MODE_FREE, 1));
    pending_items.push_back(mk(MODE_ALLOC, '0));
    pending_items.push_back(mk(MODE_FREE, 4));
    pending_items.push_back(mk(MODE_FREE, '1));
    pending_items.push_back(mk(MODE_FREE, '0));
    wait_idle();

    // Shrink the count: the list stays, the range check tightens
    write_count(2);
    pending_items.push_back(mk(MODE_ALLOC, '0));
    pending_items.push_back(mk(MODE_FREE, 3));
    wait_idle();

    // Oversized count acts as the full pool
    write_count(2047);
    pending_items.push_back(mk(MODE_FREE, '1));
    pending_items.push_back(mk(MODE_ALLOC, '0));
    pending_items.push_back(mk(MODE_CLEAR, '0));
    wait_idle();

    // Random phases, most opening with a clear
    foreach (counts[p]) begin
      write_count(CNT_W'(counts[p]));
      eff = (counts[p] > MAXB) ? MAXB : counts[p];
      if ($urandom_range(0, 3) != 0) pending_items.push_back(mk(MODE_CLEAR, '0));
      repeat (100) pending_items.push_back(rand_item(eff));
      wait_idle();
    end

    if (fail_cnt == 0 && expected_grants.size() == 0) begin
      $display("free_list_block_allocator_tb: PASS");
    end else begin
      $display("free_list_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
